// ===== rtl/core/dhp_pkg.sv =====
// Package for the degree histogram percentile block: item types, codes and constants.
package dhp_pkg;

    localparam int DHP_DEGREE_BINS = 4096;
    localparam int DHP_COUNT_BITS  = 32;

    localparam int ACTION_W = 2;
    localparam int DEGREE_W = 16;
    localparam int PCT_W    = 7;
    localparam int DEG_OUT_W = 12;
    localparam int NODE_W   = 32;
    localparam int SUM_W    = 48;
    localparam int STATUS_W = 2;

    localparam logic [PCT_W-1:0]     PCT_FULL  = 7'd100;
    localparam logic [DEG_OUT_W-1:0] EMPTY_LOW = 12'hFFF;
    localparam logic [SUM_W-1:0]     SUM_MAX   = {SUM_W{1'b1}};

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_QUERY = 2'd2
    } dhp_action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_ZERO  = 2'd2
    } dhp_status_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_ADD,
        ST_CLEAR,
        ST_SCAN
    } dhp_state_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [DEGREE_W-1:0] degree;
        logic [PCT_W-1:0]    percent;
    } dhp_in_t;

    typedef struct packed {
        logic [DEG_OUT_W-1:0] selected_degree;
        logic [DEG_OUT_W-1:0] min_degree;
        logic [DEG_OUT_W-1:0] max_degree;
        logic [NODE_W-1:0]    node_total;
        logic [SUM_W-1:0]     edge_total;
        logic [STATUS_W-1:0]  status;
        logic                 overflow;
    } dhp_out_t;

endpackage

// ===== rtl/core/degree_histogram_percentile.sv =====
// Degree histogram with running totals, extremes and a percentile query.
//
//  Channel   Signals                          Direction  Transfer condition
//  --------  -------------------------------  ---------  ---------------------------------
//  item      start, busy, in_item             in         rising edge with start high, busy low
//  result    result_valid, result             out        every cycle result_valid is high
//  config    cfg_write, cfg_data              in         rising edge with cfg_write high
//
// For an add the bin is read at the accepting edge from a registered memory
// port and written back on the next edge, when the result is registered.
// An unused action code has its result registered at the accepting edge. A clear
// sweeps zero into every bin through the single write port. A query forms percent
// times nodes at the transfer, then walks the bins one per cycle through the read
// port, up to the last bin. Each nonzero count, scaled by one hundred, is taken off
// that product until a hundred times the next count plus one exceeds what is left,
// which matches the floored threshold exactly.
// After reset the block sweeps all DEGREE_BINS bins to zero and holds busy high
// meanwhile; configuration writes are taken at any time. The receiver cannot stall:
// each result is shown for exactly one cycle, in the cycle busy returns low.
module degree_histogram_percentile
    import dhp_pkg::*;
#(
    parameter int DEGREE_BINS = DHP_DEGREE_BINS,
    parameter int COUNT_BITS  = DHP_COUNT_BITS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  dhp_in_t  in_item,
    output logic     result_valid,
    output dhp_out_t result,
    input  logic     cfg_write,
    input  logic     cfg_data
);

    // Bin index width, scan counter width (it must reach DEGREE_BINS itself),
    // the width of the running extremes, and the width of percent times nodes.
    localparam int BIN_AW  = $clog2(DEGREE_BINS);
    localparam int SCAN_W  = $clog2(DEGREE_BINS + 1);
    localparam int LOW_W   = (BIN_AW > DEG_OUT_W) ? BIN_AW : DEG_OUT_W;
    localparam int PROD_W  = COUNT_BITS + PCT_W;
    localparam int DEG_EXT = DEGREE_W + 1;

    // The histogram itself, one count per bin, with a registered read port.
    logic [COUNT_BITS-1:0] bin_mem [DEGREE_BINS];
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic [BIN_AW-1:0]     rd_addr;
    logic                  wr_en;
    logic [BIN_AW-1:0]     wr_addr;
    logic [COUNT_BITS-1:0] wr_data;

    dhp_state_t state_reg, state_next;

    logic                  enable_reg, enable_next;
    logic [COUNT_BITS-1:0] nodes_reg, nodes_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [LOW_W-1:0]      low_reg, low_next;
    logic [LOW_W-1:0]      high_reg, high_next;
    logic                  ovf_reg, ovf_next;

    // Captured add item.
    logic [DEGREE_W-1:0]   deg_reg, deg_next;
    logic [BIN_AW-1:0]     bin_reg, bin_next;
    logic                  big_reg, big_next;

    // Sweep and scan address, and the pipeline stage that checks read data.
    logic [SCAN_W-1:0]     scan_reg, scan_next;
    logic                  chk_valid_reg, chk_valid_next;
    logic [BIN_AW-1:0]     chk_idx_reg, chk_idx_next;
    logic                  any_reg, any_next;
    logic [BIN_AW-1:0]     last_reg, last_next;

    // Percent times nodes, less a hundred for every node counted so far in the scan.
    logic [PROD_W-1:0]     need_reg, need_next;

    dhp_out_t              res_reg, res_next;
    logic                  res_valid_reg, res_valid_next;

    // Datapath helpers.
    logic                  in_big;
    logic [BIN_AW-1:0]     in_bin;
    logic [PCT_W-1:0]      pct_clamped;
    logic [PROD_W-1:0]     bin_scaled;
    logic [PROD_W:0]       bin_reach;
    logic [SUM_W:0]        sum_add;
    logic [COUNT_BITS-1:0] bin_inc;
    logic [COUNT_BITS-1:0] nodes_inc;
    logic                  emit;
    logic [BIN_AW-1:0]     sel_idx;
    dhp_status_t           stat_val;
    logic                  any_v;
    logic [BIN_AW-1:0]     last_v;

    assign in_big = {1'b0, in_item.degree} > DEG_EXT'(DEGREE_BINS - 1);
    assign in_bin = in_big ? BIN_AW'(DEGREE_BINS - 1) : in_item.degree[BIN_AW-1:0];
    assign pct_clamped = (in_item.percent > PCT_FULL) ? PCT_FULL : in_item.percent;

    // The running count reaches floor(product / 100) exactly when a hundred times the
    // count plus one exceeds the product, so the scan never has to divide.
    assign bin_scaled = PROD_W'(rd_data_reg) * PROD_W'(PCT_FULL);
    assign bin_reach  = {1'b0, bin_scaled} + (PROD_W + 1)'(PCT_FULL);

    assign sum_add   = {1'b0, sum_reg} + (SUM_W + 1)'(deg_reg);
    assign bin_inc   = (&rd_data_reg) ? rd_data_reg : rd_data_reg + COUNT_BITS'(1);
    assign nodes_inc = (&nodes_reg) ? nodes_reg : nodes_reg + COUNT_BITS'(1);

    // In idle the read port looks up the bin of the item at the port, so an add
    // has its old count ready in the cycle after the transfer.
    assign rd_addr = (state_reg == ST_IDLE) ? in_bin : scan_reg[BIN_AW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        enable_next    = cfg_write ? cfg_data : enable_reg;
        nodes_next     = nodes_reg;
        sum_next       = sum_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        ovf_next       = ovf_reg;
        deg_next       = deg_reg;
        bin_next       = bin_reg;
        big_next       = big_reg;
        scan_next      = scan_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        any_next       = any_reg;
        last_next      = last_reg;
        need_next      = need_reg;
        wr_en          = 1'b0;
        wr_addr        = scan_reg[BIN_AW-1:0];
        wr_data        = '0;
        emit           = 1'b0;
        sel_idx        = '0;
        stat_val       = STAT_OK;
        any_v          = any_reg;
        last_v         = last_reg;

        case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                wr_en     = 1'b1;
                scan_next = scan_reg + SCAN_W'(1);
                if (scan_reg == SCAN_W'(DEGREE_BINS - 1))
                begin
                    state_next = ST_IDLE;
                    emit       = (state_reg == ST_CLEAR);
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    deg_next = in_item.degree;
                    bin_next = in_bin;
                    big_next = in_big;
                    case (in_item.action)
                        ACT_ADD:
                        begin
                            state_next = ST_ADD;
                        end
                        ACT_CLEAR:
                        begin
                            nodes_next = '0;
                            sum_next   = '0;
                            low_next   = LOW_W'(EMPTY_LOW);
                            high_next  = '0;
                            ovf_next   = 1'b0;
                            scan_next  = '0;
                            state_next = ST_CLEAR;
                        end
                        ACT_QUERY:
                        begin
                            need_next  = PROD_W'(pct_clamped) * PROD_W'(nodes_reg);
                            scan_next  = '0;
                            any_next   = 1'b0;
                            last_next  = '0;
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end

            ST_ADD:
            begin
                emit       = 1'b1;
                state_next = ST_IDLE;
                wr_addr    = bin_reg;
                wr_data    = bin_inc;
                if (deg_reg == '0)
                begin
                    stat_val = STAT_ZERO;
                end
                else
                begin
                    wr_en      = enable_reg;
                    nodes_next = nodes_inc;
                    sum_next   = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
                    ovf_next   = ovf_reg | big_reg;
                    if (LOW_W'(bin_reg) < low_reg)
                    begin
                        low_next = LOW_W'(bin_reg);
                    end
                    if (LOW_W'(bin_reg) > high_reg)
                    begin
                        high_next = LOW_W'(bin_reg);
                    end
                end
            end

            ST_SCAN:
            begin
                if (scan_reg < SCAN_W'(DEGREE_BINS))
                begin
                    scan_next      = scan_reg + SCAN_W'(1);
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_reg[BIN_AW-1:0];
                end
                if (chk_valid_reg)
                begin
                    if (rd_data_reg != '0)
                    begin
                        any_v     = 1'b1;
                        last_v    = chk_idx_reg;
                        any_next  = 1'b1;
                        last_next = chk_idx_reg;
                        need_next = need_reg - bin_scaled;
                    end
                    if ((rd_data_reg != '0) && (bin_reach > {1'b0, need_reg}))
                    begin
                        emit           = 1'b1;
                        sel_idx        = chk_idx_reg;
                        chk_valid_next = 1'b0;
                        state_next     = ST_IDLE;
                    end
                    else if (chk_idx_reg == BIN_AW'(DEGREE_BINS - 1))
                    begin
                        emit           = 1'b1;
                        sel_idx        = any_v ? last_v : '0;
                        stat_val       = any_v ? STAT_OK : STAT_EMPTY;
                        chk_valid_next = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res_valid_next           = emit;
        res_next.selected_degree = DEG_OUT_W'(sel_idx);
        res_next.min_degree      = low_next[DEG_OUT_W-1:0];
        res_next.max_degree      = high_next[DEG_OUT_W-1:0];
        res_next.node_total      = NODE_W'(nodes_next);
        res_next.edge_total      = sum_next;
        res_next.status          = stat_val;
        res_next.overflow        = ovf_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bin_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= bin_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            enable_reg    <= 1'b1;
            nodes_reg     <= '0;
            sum_reg       <= '0;
            low_reg       <= LOW_W'(EMPTY_LOW);
            high_reg      <= '0;
            ovf_reg       <= 1'b0;
            scan_reg      <= '0;
            chk_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            enable_reg    <= enable_next;
            nodes_reg     <= nodes_next;
            sum_reg       <= sum_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            ovf_reg       <= ovf_next;
            scan_reg      <= scan_next;
            chk_valid_reg <= chk_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        deg_reg     <= deg_next;
        bin_reg     <= bin_next;
        big_reg     <= big_next;
        chk_idx_reg <= chk_idx_next;
        any_reg     <= any_next;
        last_reg    <= last_next;
        need_reg    <= need_next;
        res_reg     <= res_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

`ifndef SYNTHESIS
    // A result only ever follows a cycle in which an item was taken or being worked on.
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy || start))
        else $error("result shown without an item in progress");

    // An empty histogram never yields a selected degree.
    a_empty_selects_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status == STAT_EMPTY)) |-> (result.selected_degree == '0))
        else $error("empty query returned a nonzero degree");

    // Once any degree is recorded the running minimum cannot exceed the maximum.
    a_extremes_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (nodes_reg != '0) |-> (low_reg <= high_reg))
        else $error("running minimum above running maximum");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the degree histogram percentile block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dhp_pkg::*;

    // The one action code that the package leaves without a name. The block must treat it
    // as a no-op that still returns a result.
    localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;
    localparam logic [PCT_W-1:0]    PCT_TOP   = {PCT_W{1'b1}};
    localparam logic [DEGREE_W-1:0] DEG_TOP   = {DEGREE_W{1'b1}};
    localparam int TOP_BIN = DHP_DEGREE_BINS - 1;

    // A clear sweeps every bin and a query may walk every bin, so the longest quiet stretch
    // grows with DEGREE_BINS. The limit allows for that several times over.
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int ITEMS_PER_PHASE = 133;
    localparam int TAIL_CYCLES     = 64;
    localparam int REPORT_LIMIT    = 10;

    // Keeps a private copy of the histogram and running totals, works out the statistics
    // that each accepted item should return, and checks the block's results against them.
    class degree_stats_tracker;
        bit [DHP_COUNT_BITS-1:0] bin_count [DHP_DEGREE_BINS];
        bit [NODE_W-1:0]    nodes;
        bit [SUM_W-1:0]     edge_sum;
        bit [DEG_OUT_W-1:0] low_deg;
        bit [DEG_OUT_W-1:0] high_deg;
        bit                 saturated;
        bit                 hist_on;
        dhp_out_t           pending_stats [$];
        int errors;
        int n_items;
        int n_adds;
        int n_zero;
        int n_clamped;
        int n_queries;
        int n_empty;
        int n_clears;
        int n_spare;
        int n_results;

        function new();
            hist_on = 1'b1;
            clear_histogram();
        endfunction

        function void clear_histogram();
            foreach (bin_count[i])
                bin_count[i] = '0;
            nodes     = '0;
            edge_sum  = '0;
            low_deg   = EMPTY_LOW;
            high_deg  = '0;
            saturated = 1'b0;
        endfunction

        function void set_hist_enable(bit value);
            hist_on = value;
        endfunction

        function int pending();
            return pending_stats.size();
        endfunction

        // Applies one accepted item to the private state and queues the result it must give.
        function void record_item(dhp_in_t it);
            dhp_out_t          stats;
            dhp_status_t       st;
            logic [DEG_OUT_W-1:0] sel;
            int unsigned       bin;
            bit [PCT_W-1:0]    pct;
            longint unsigned   threshold;
            longint unsigned   acc;
            int unsigned       last;
            bit                any;
            bit                found;

            st = STAT_OK;
            sel = '0;
            n_items++;
            case (it.action)
                ACT_ADD:
                begin
                    n_adds++;
                    if (it.degree == '0)
                    begin
                        st = STAT_ZERO;
                        n_zero++;
                    end
                    else
                    begin
                        // Degrees past the top bin land in it, and mark the overflow, but
                        // the edge total still takes the full degree.
                        if (it.degree > TOP_BIN)
                        begin
                            bin = TOP_BIN;
                            saturated = 1'b1;
                            n_clamped++;
                        end
                        else
                            bin = it.degree;
                        if (hist_on && bin_count[bin] != '1)
                            bin_count[bin]++;
                        if (nodes != '1)
                            nodes++;
                        if (SUM_MAX - edge_sum < SUM_W'(it.degree))
                            edge_sum = SUM_MAX;
                        else
                            edge_sum = edge_sum + SUM_W'(it.degree);
                        if (bin < low_deg)
                            low_deg = DEG_OUT_W'(bin);
                        if (bin > high_deg)
                            high_deg = DEG_OUT_W'(bin);
                    end
                end
                ACT_CLEAR:
                begin
                    n_clears++;
                    clear_histogram();
                end
                ACT_QUERY:
                begin
                    n_queries++;
                    pct = (it.percent > PCT_FULL) ? PCT_FULL : it.percent;
                    threshold = (64'(pct) * 64'(nodes)) / 64'(PCT_FULL);
                    acc = 0;
                    last = 0;
                    any = 1'b0;
                    found = 1'b0;
                    for (int i = 0; i < DHP_DEGREE_BINS && !found; i++)
                    begin
                        if (bin_count[i] != '0)
                        begin
                            any = 1'b1;
                            last = i;
                            acc = acc + bin_count[i];
                            if (acc >= threshold)
                            begin
                                sel = DEG_OUT_W'(i);
                                found = 1'b1;
                            end
                        end
                    end
                    // No bin populated at all, which also happens when every add went in
                    // with the histogram switched off.
                    if (!any)
                    begin
                        st = STAT_EMPTY;
                        n_empty++;
                    end
                    else if (!found)
                        sel = DEG_OUT_W'(last);
                end
                default:
                    n_spare++;
            endcase

            stats.selected_degree = sel;
            stats.min_degree      = low_deg;
            stats.max_degree      = high_deg;
            stats.node_total      = nodes;
            stats.edge_total      = edge_sum;
            stats.status          = st;
            stats.overflow        = saturated;
            pending_stats.insert(pending_stats.size(), stats);
        endfunction

        function void check_result(dhp_out_t got);
            dhp_out_t want;
            bit       bad;

            n_results++;
            if (pending_stats.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("error: result %0d arrived with nothing outstanding", n_results);
                return;
            end
            want = pending_stats.pop_front();
            bad = (got.selected_degree !== want.selected_degree)
                || (got.min_degree !== want.min_degree)
                || (got.max_degree !== want.max_degree)
                || (got.node_total !== want.node_total)
                || (got.edge_total !== want.edge_total)
                || (got.status !== want.status)
                || (got.overflow !== want.overflow);
            if (bad)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                begin
                    $display("error: result %0d expected sel=%0d min=%0d max=%0d",
                        n_results, want.selected_degree, want.min_degree, want.max_degree);
                    $display("       nodes=%0d edges=%0d status=%0d ovf=%0d",
                        want.node_total, want.edge_total, want.status, want.overflow);
                    $display("       result %0d actual   sel=%0d min=%0d max=%0d",
                        n_results, got.selected_degree, got.min_degree, got.max_degree);
                    $display("       nodes=%0d edges=%0d status=%0d ovf=%0d",
                        got.node_total, got.edge_total, got.status, got.overflow);
                end
            end
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    dhp_in_t  in_item;
    logic     result_valid;
    dhp_out_t result;
    logic     cfg_write;
    logic     cfg_data;

    degree_stats_tracker board;
    int idle_cycles;

    degree_histogram_percentile dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .in_item      (in_item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // The monitor looks at every rising edge. Because all inputs and, by assumption, all of
    // the block's outputs change only through nonblocking updates, the values read here are
    // the ones that held just before the edge, whatever order the processes run in. The
    // result is checked before the new item is noted, though the queue order does not
    // depend on it: a result can never belong to the item accepted at the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid === 1'b1)
                board.check_result(result);
            if (start && busy === 1'b0)
                board.record_item(in_item);
            if (cfg_write)
                board.set_hist_enable(cfg_data);
            if (result_valid === 1'b1 || (start && busy === 1'b0))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // The watchdog is read on the falling edge so that it never races the monitor. It ends
    // the run if nothing at all is transferred for too long.
    initial
    begin
        do
            @(negedge clk);
        while (idle_cycles < WATCHDOG_LIMIT);
        $display("error: no transfer for %0d cycles, %0d results still outstanding",
            idle_cycles, board.pending());
        $display("simulation failed");
        $finish;
    end

    function automatic dhp_in_t make_item(logic [ACTION_W-1:0] action, int degree, int percent);
        dhp_in_t it;
        it.action  = action;
        it.degree  = DEGREE_W'(degree);
        it.percent = PCT_W'(percent);
        return it;
    endfunction

    // Random item, weighted heavily towards adds so that the histogram fills up and the
    // queries have something to walk. Clears are kept rare, both because they would keep
    // emptying the histogram and because each one costs a full sweep of the bins. Fields
    // that an action does not use carry random bits.
    function automatic dhp_in_t random_item();
        dhp_in_t it;
        int      roll;

        it.degree  = DEGREE_W'($urandom);
        it.percent = PCT_W'($urandom);
        roll = $urandom_range(99);
        if (roll < 72)
        begin
            it.action = ACT_ADD;
            case ($urandom_range(9))
                0: it.degree = '0;
                1: ;
                2: it.degree = DEGREE_W'($urandom_range(DHP_DEGREE_BINS - 4, DHP_DEGREE_BINS + 4));
                3: it.degree = DEGREE_W'($urandom_range(1, TOP_BIN));
                default: it.degree = DEGREE_W'($urandom_range(1, 64));
            endcase
        end
        else if (roll < 90)
        begin
            it.action = ACT_QUERY;
            // Most queries ask for a real percentile; the rest keep random bits, which may go past a hundred.
            if ($urandom_range(7) != 0)
                it.percent = PCT_W'($urandom_range(0, PCT_FULL));
        end
        else if (roll < 94)
            it.action = ACT_CLEAR;
        else
            it.action = ACT_SPARE;
        return it;
    endfunction

    // Presents one item and returns at the edge where it is transferred, with start still
    // high. A gap lowers start first and puts random noise on the item bus meanwhile. With
    // no gap, start is simply driven high again at the transfer edge, so it never sees two
    // updates in one time step.
    task automatic send_item(input dhp_in_t item, input int gap);
        if (gap > 0)
        begin
            start   <= 1'b0;
            in_item <= random_item();
            repeat (gap)
                @(posedge clk);
        end
        in_item <= item;
        start   <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    // Stops sending and waits until every outstanding result has come back. Every item
    // gives exactly one result, so an empty queue means the block is idle again.
    task automatic drain_results();
        start <= 1'b0;
        do
            @(negedge clk);
        while (board.pending() != 0);
        @(posedge clk);
    endtask

    // Only ever called with the block idle and start low.
    task automatic write_hist_enable(input logic value);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        int phase_idle [4];
        bit phase_hist [4];
        int burst_left;
        int gap;

        // The receiver cannot hold results off, so only the sender's pacing varies.
        phase_idle = '{0, 50, 0, 14};
        phase_hist = '{1'b1, 1'b0, 1'b1, 1'b1};
        burst_left = 0;
        board = new();
        idle_cycles = 0;
        rst_n     = 1'b0;
        start     = 1'b0;
        in_item   = '0;
        cfg_write = 1'b0;
        cfg_data  = 1'b0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening. The first transfer also waits out the block's clearing pass
        // after reset, since busy stays high until the bins have been swept.
        send_item(make_item(ACT_QUERY, 0, 50), 0);                // empty histogram
        send_item(make_item(ACT_ADD, 0, 0), 0);                   // zero degree ignored
        send_item(make_item(ACT_ADD, 1, PCT_TOP), 0);
        send_item(make_item(ACT_ADD, TOP_BIN, 0), 0);
        send_item(make_item(ACT_ADD, DHP_DEGREE_BINS, 0), 0);     // first clamped degree
        send_item(make_item(ACT_ADD, DEG_TOP, 0), 0);
        send_item(make_item(ACT_ADD, 17, 0), 0);
        send_item(make_item(ACT_QUERY, DEG_TOP, 0), 0);
        send_item(make_item(ACT_QUERY, 0, 50), 0);
        send_item(make_item(ACT_QUERY, 0, PCT_FULL), 0);
        send_item(make_item(ACT_QUERY, 0, PCT_TOP), 0);           // clipped to a hundred
        send_item(make_item(ACT_SPARE, DEG_TOP, PCT_TOP), 0);
        send_item(make_item(ACT_CLEAR, DEG_TOP, PCT_TOP), 0);
        send_item(make_item(ACT_QUERY, 0, PCT_FULL), 0);          // empty again after clear

        // With the histogram switched off the totals still move but a query sees no bins.
        drain_results();
        write_hist_enable(1'b0);
        send_item(make_item(ACT_ADD, 9, 0), 0);
        send_item(make_item(ACT_ADD, 300, 0), 0);
        send_item(make_item(ACT_QUERY, 0, 50), 0);
        drain_results();
        write_hist_enable(1'b1);
        send_item(make_item(ACT_ADD, 5, 0), 0);
        send_item(make_item(ACT_QUERY, 0, 1), 0);
        send_item(make_item(ACT_ADD, DEG_TOP, 0), 0);
        send_item(make_item(ACT_QUERY, 0, 99), 0);

        // Random phases, each with its own pacing and histogram setting. The block is idle
        // at every boundary, so the register write never lands on a transfer in flight.
        for (int p = 0; p < 4; p++)
        begin
            drain_results();
            write_hist_enable(phase_hist[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Now and then the sender holds back until the block has caught up.
                if ($urandom_range(49) == 0)
                    drain_results();
                // Short bursts with no gaps break up the idle phases.
                if (burst_left > 0)
                begin
                    burst_left--;
                    gap = 0;
                end
                else if ($urandom_range(15) == 0)
                begin
                    burst_left = 8;
                    gap = 0;
                end
                else
                    gap = ($urandom_range(99) < phase_idle[p]) ? $urandom_range(1, 6) : 0;
                send_item(random_item(), gap);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES)
            @(posedge clk);

        $display("Covered %0d items: %0d adds (%0d zero, %0d clamped), %0d queries (%0d empty),",
            board.n_items, board.n_adds, board.n_zero, board.n_clamped, board.n_queries,
            board.n_empty);
        $display("%0d clears and %0d spare codes; checked %0d results over four pacing phases.",
            board.n_clears, board.n_spare, board.n_results);
        if (board.errors == 0 && board.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
